[design/bsle_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsle_pkg
// Shared types and constants for the bounded stack/list engine.
// ----------------------------------------------------------------------------
package bsle_pkg;

    localparam int DATA_W        = 32;
    localparam int ACTION_W      = 4;
    localparam int POS_W         = 5;
    localparam int STATUS_W      = 2;
    localparam int COUNT_OUT_W   = 6;
    localparam int DEPTH_DEFAULT = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH      = 4'd0,
        ACT_POP       = 4'd1,
        ACT_INSERT    = 4'd2,
        ACT_REMOVE    = 4'd3,
        ACT_READ      = 4'd4,
        ACT_TOP       = 4'd5,
        ACT_SORT_ASC  = 4'd6,
        ACT_SORT_DESC = 4'd7,
        ACT_CLEAR     = 4'd8
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 2'd0,
        STS_FULL   = 2'd1,
        STS_EMPTY  = 2'd2,
        STS_BADPOS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_MOVE,
        ST_SORT_FIRST,
        ST_SORT_RUN,
        ST_SORT_TAIL
    } state_t;

endpackage : bsle_pkg
`default_nettype wire

[design/bounded_stack_list_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_stack_list_engine
// Array stack with positional insert/remove/read and in-place sort.
// ----------------------------------------------------------------------------
// Entries live in a single-port-read, single-port-write RAM, and every
// transaction returns exactly one response. Push, pop, clear, unknown actions,
// a sort of fewer than two entries and any command that fails complete in the
// accept cycle; read and top wait for the registered RAM read. Insert shifts the
// entries from the position up one slot, remove shifts those above it down one
// slot: one entry moves per cycle, limited by the one RAM read port. Sort is a
// bubble sort through one shared signed comparator, one entry per cycle, in
// passes over a shrinking range, stopping after a pass with no swap or once the
// range is down to two entries. A new command is accepted only when the engine
// is idle.
// ----------------------------------------------------------------------------
module bounded_stack_list_engine
    import bsle_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cmd_valid,
    output logic                           cmd_ready,
    input  wire logic [ACTION_W-1:0]       action,
    input  wire logic [POS_W-1:0]          position,
    input  wire logic signed [DATA_W-1:0]  item_value,
    output logic                           rsp_valid,
    input  wire logic                      rsp_ready,
    output logic signed [DATA_W-1:0]       read_value,
    output logic [STATUS_W-1:0]            status,
    output logic [COUNT_OUT_W-1:0]         entry_count
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    state_t                  state_reg,   state_next;
    logic [CW-1:0]           count_reg,   count_next;
    logic [CW-1:0]           idx_reg,     idx_next;
    logic [CW-1:0]           rem_reg,     rem_next;
    logic [CW-1:0]           last_reg,    last_next;
    logic                    pend_reg,    pend_next;
    logic [AW-1:0]           pend_addr_reg, pend_addr_next;
    logic [AW-1:0]           pos_reg,     pos_next;
    logic [DATA_W-1:0]       val_reg,     val_next;
    logic [DATA_W-1:0]       carry_reg,   carry_next;
    logic                    up_reg,      up_next;
    logic                    desc_reg,    desc_next;
    logic                    swapped_reg, swapped_next;

    logic                    rsp_valid_reg,   rsp_valid_next;
    logic [DATA_W-1:0]       read_value_reg,  read_value_next;
    status_t                 status_reg,      status_next;
    logic [COUNT_OUT_W-1:0]  entry_count_reg, entry_count_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [DATA_W-1:0]       ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [DATA_W-1:0]       ram_rdata;

    logic                    cmd_fire;
    logic                    full;
    logic                    empty;
    logic [CMP_W-1:0]        pos_ext;
    logic [CMP_W-1:0]        cnt_ext;
    logic                    out_of_order;

    bsle_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_ready   = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign cmd_fire    = cmd_valid && cmd_ready;
    assign rsp_valid   = rsp_valid_reg;
    assign read_value  = read_value_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count_reg);

    // shared comparator: carry holds the entry bubbling toward the top
    assign out_of_order = desc_reg ? ($signed(ram_rdata) > $signed(carry_reg))
                                   : ($signed(carry_reg) > $signed(ram_rdata));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        rem_reg         <= rem_next;
        last_reg        <= last_next;
        pend_addr_reg   <= pend_addr_next;
        pos_reg         <= pos_next;
        val_reg         <= val_next;
        carry_reg       <= carry_next;
        up_reg          <= up_next;
        desc_reg        <= desc_next;
        swapped_reg     <= swapped_next;
        read_value_reg  <= read_value_next;
        status_reg      <= status_next;
        entry_count_reg <= entry_count_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        rem_next         = rem_reg;
        last_next        = last_reg;
        pend_next        = pend_reg;
        pend_addr_next   = pend_addr_reg;
        pos_next         = pos_reg;
        val_next         = val_reg;
        carry_next       = carry_reg;
        up_next          = up_reg;
        desc_next        = desc_reg;
        swapped_next     = swapped_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        read_value_next  = read_value_reg;
        status_next      = status_reg;
        entry_count_next = entry_count_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    // default: respond with the entry count after this command
                    rsp_valid_next  = 1'b1;
                    read_value_next = '0;
                    status_next     = STS_OK;
                    unique case (action)
                        ACT_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = STS_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(count_reg);
                                ram_wdata  = item_value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_POP:
                        begin
                            if (empty)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        ACT_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = STS_FULL;
                            end
                            else if (pos_ext > cnt_ext)
                            begin
                                status_next = STS_BADPOS;
                            end
                            else
                            begin
                                rsp_valid_next = rsp_valid_reg && !rsp_ready;
                                pos_next       = AW'(position);
                                val_next       = item_value;
                                idx_next       = count_reg - CW'(1);
                                rem_next       = CW'(cnt_ext - pos_ext);
                                pend_next      = 1'b0;
                                up_next        = 1'b1;
                                state_next     = ST_MOVE;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (empty)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else if (pos_ext >= cnt_ext)
                            begin
                                status_next = STS_BADPOS;
                            end
                            else
                            begin
                                rsp_valid_next = rsp_valid_reg && !rsp_ready;
                                idx_next       = CW'(pos_ext + CMP_W'(1));
                                rem_next       = CW'(cnt_ext - pos_ext - CMP_W'(1));
                                pend_next      = 1'b0;
                                up_next        = 1'b0;
                                state_next     = ST_MOVE;
                            end
                        end
                        ACT_READ:
                        begin
                            if (empty)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else if (pos_ext >= cnt_ext)
                            begin
                                status_next = STS_BADPOS;
                            end
                            else
                            begin
                                rsp_valid_next = rsp_valid_reg && !rsp_ready;
                                ram_raddr      = AW'(position);
                                state_next     = ST_READ_WAIT;
                            end
                        end
                        ACT_TOP:
                        begin
                            if (empty)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else
                            begin
                                rsp_valid_next = rsp_valid_reg && !rsp_ready;
                                ram_raddr      = AW'(count_reg - CW'(1));
                                state_next     = ST_READ_WAIT;
                            end
                        end
                        ACT_SORT_ASC,
                        ACT_SORT_DESC:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                rsp_valid_next = rsp_valid_reg && !rsp_ready;
                                desc_next      = (action == ACT_SORT_DESC);
                                ram_raddr      = '0;
                                idx_next       = CW'(1);
                                last_next      = count_reg - CW'(1);
                                swapped_next   = 1'b0;
                                state_next     = ST_SORT_FIRST;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    entry_count_next = COUNT_OUT_W'(count_next);
                end
            end

            ST_READ_WAIT:
            begin
                rsp_valid_next   = 1'b1;
                read_value_next  = ram_rdata;
                status_next      = STS_OK;
                entry_count_next = COUNT_OUT_W'(count_reg);
                state_next       = ST_IDLE;
            end

            ST_MOVE:
            begin
                // read one entry per cycle, write it one slot over in the next cycle
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (rem_reg != '0)
                begin
                    ram_raddr      = idx_reg[AW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = up_reg ? (idx_reg[AW-1:0] + AW'(1))
                                            : (idx_reg[AW-1:0] - AW'(1));
                    idx_next       = up_reg ? (idx_reg - CW'(1)) : (idx_reg + CW'(1));
                    rem_next       = rem_reg - CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (up_reg)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = pos_reg;
                            ram_wdata  = val_reg;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                        rsp_valid_next   = 1'b1;
                        read_value_next  = '0;
                        status_next      = STS_OK;
                        entry_count_next = COUNT_OUT_W'(count_next);
                        state_next       = ST_IDLE;
                    end
                end
            end

            ST_SORT_FIRST:
            begin
                carry_next = ram_rdata;
                ram_raddr  = idx_reg[AW-1:0];
                idx_next   = idx_reg + CW'(1);
                state_next = ST_SORT_RUN;
            end

            ST_SORT_RUN:
            begin
                // ram_rdata is entry idx-1; settle the slot below it
                ram_we    = 1'b1;
                ram_waddr = AW'(idx_reg - CW'(2));
                if (out_of_order)
                begin
                    ram_wdata    = ram_rdata;
                    swapped_next = 1'b1;
                end
                else
                begin
                    ram_wdata  = carry_reg;
                    carry_next = ram_rdata;
                end
                if (idx_reg == last_reg + CW'(1))
                begin
                    state_next = ST_SORT_TAIL;
                end
                else
                begin
                    ram_raddr = idx_reg[AW-1:0];
                    idx_next  = idx_reg + CW'(1);
                end
            end

            ST_SORT_TAIL:
            begin
                ram_we    = 1'b1;
                ram_waddr = last_reg[AW-1:0];
                ram_wdata = carry_reg;
                if (!swapped_reg || (last_reg == CW'(1)))
                begin
                    rsp_valid_next   = 1'b1;
                    read_value_next  = '0;
                    status_next      = STS_OK;
                    entry_count_next = COUNT_OUT_W'(count_reg);
                    state_next       = ST_IDLE;
                end
                else
                begin
                    last_next    = last_reg - CW'(1);
                    ram_raddr    = '0;
                    idx_next     = CW'(1);
                    swapped_next = 1'b0;
                    state_next   = ST_SORT_FIRST;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (CW'(ram_waddr) <= count_reg))
        else $error("RAM write beyond held entries");

    a_busy_no_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !rsp_valid_reg)
        else $error("response pending while a multi-cycle transaction runs");

    a_count_stable_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != ST_IDLE) && $past(state_reg != ST_IDLE)) |-> $stable(count_reg))
        else $error("entry count changed mid-transaction");

endmodule : bounded_stack_list_engine
`default_nettype wire

[design/bsle_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsle_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bsle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : bsle_ram
`default_nettype wire
